@@ sv/tlca_pkg.sv @@
// Shared types, constants and command/status structs for the LCA jump-pointer engine.
package tlca_pkg;

  localparam int NODE_COUNT  = 1024;
  localparam int ID_W        = $clog2(NODE_COUNT);
  localparam int DEPTH_W     = ID_W + 1;
  localparam int DIFF_W      = DEPTH_W + 1;
  localparam int IN_TDATA_W  = ((2 * ID_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((ID_W + 7) / 8) * 8;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_QUERY  = 1'b1;

  localparam logic STATUS_OK       = 1'b0;
  localparam logic STATUS_REJECTED = 1'b1;

  typedef logic [ID_W-1:0]    id_t;
  typedef logic [DEPTH_W-1:0] depth_t;

  typedef struct packed {
    depth_t depth;
    id_t    parent;
    id_t    jump;
  } entry_t;

  // Source of the node-table read address.
  typedef enum logic [2:0] {
    SRC_IN_A,
    SRC_IN_B,
    SRC_JA,
    SRC_JB,
    SRC_PA,
    SRC_PB,
    SRC_RD_JUMP
  } src_t;

  // Destination of the registered read data.
  typedef enum logic [2:0] {
    CAP_NONE,
    CAP_A,
    CAP_B,
    CAP_T,
    CAP_T2
  } cap_t;

  typedef struct packed {
    logic load_in;
    logic rd_en;
    src_t rd_src;
    cap_t cap;
    logic swap;
    logic wr_node;
    logic wr_clr;
    id_t  clr_addr;
    logic res_load;
    logic res_ok;
    logic res_anc;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic op;
    logic a_zero;
    logic da_zero;
    logic b_zero;
    logic db_zero;
    logic a_deeper;
    logic b_deeper;
    logic t_ok;
    logic a_eq_b;
    logic ja_ne_jb;
    logic out_busy;
  } stat_t;

endpackage

@@ sv/tlca_dpath.sv @@
// Datapath: node table memory, walk registers, result and output registers.
module tlca_dpath (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_op,
  input  tlca_pkg::id_t                      in_a,
  input  tlca_pkg::id_t                      in_b,
  input  tlca_pkg::cmd_t                     cmd,
  output tlca_pkg::stat_t                    stat,
  input  logic                               out_tready,
  output logic                               out_tvalid,
  output tlca_pkg::id_t                      out_anc,
  output logic                               out_st
);

  tlca_pkg::entry_t mem [tlca_pkg::NODE_COUNT];

  logic             in_op_r;
  tlca_pkg::id_t    in_a_r;
  tlca_pkg::id_t    in_b_r;
  tlca_pkg::id_t    a_r;
  tlca_pkg::id_t    b_r;
  tlca_pkg::entry_t ea_r;
  tlca_pkg::entry_t eb_r;
  tlca_pkg::depth_t dt_r;
  tlca_pkg::id_t    jt_r;
  tlca_pkg::depth_t dt2_r;
  tlca_pkg::id_t    raddr_r;
  tlca_pkg::entry_t rd_q_r;
  tlca_pkg::id_t    res_anc_r;
  logic             res_st_r;
  logic             out_valid_r;
  tlca_pkg::id_t    out_anc_r;
  logic             out_st_r;

  tlca_pkg::id_t                 rd_addr;
  tlca_pkg::id_t                 wr_addr;
  tlca_pkg::entry_t              wr_data;
  logic                          wr_en;
  logic [tlca_pkg::DIFF_W-1:0]   gap_lo;
  logic [tlca_pkg::DIFF_W-1:0]   gap_hi;
  logic                          gaps_equal;

  always_comb begin
    case (cmd.rd_src)
      tlca_pkg::SRC_IN_A:    rd_addr = in_a_r;
      tlca_pkg::SRC_IN_B:    rd_addr = in_b_r;
      tlca_pkg::SRC_JA:      rd_addr = ea_r.jump;
      tlca_pkg::SRC_JB:      rd_addr = eb_r.jump;
      tlca_pkg::SRC_PA:      rd_addr = ea_r.parent;
      tlca_pkg::SRC_PB:      rd_addr = eb_r.parent;
      tlca_pkg::SRC_RD_JUMP: rd_addr = rd_q_r.jump;
      default:               rd_addr = in_a_r;
    endcase
  end

  // Depth gaps parent->jump and jump->jump-of-jump, compared modulo 2^DIFF_W.
  assign gap_lo     = {1'b0, dt_r} - {1'b0, eb_r.depth};
  assign gap_hi     = {1'b0, dt2_r} - {1'b0, dt_r};
  assign gaps_equal = (gap_lo == gap_hi);

  always_comb begin
    wr_en   = cmd.wr_clr | cmd.wr_node;
    wr_addr = cmd.wr_clr ? cmd.clr_addr : in_a_r;
    if (cmd.wr_clr) begin
      wr_data = '0;
    end else begin
      wr_data.depth  = eb_r.depth + tlca_pkg::DEPTH_W'(1);
      wr_data.parent = b_r;
      wr_data.jump   = gaps_equal ? jt_r : b_r;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_en) begin
      rd_q_r  <= mem[rd_addr];
      raddr_r <= rd_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      in_op_r <= in_op;
      in_a_r  <= in_a;
      in_b_r  <= in_b;
    end
    if (cmd.swap) begin
      a_r  <= b_r;
      ea_r <= eb_r;
      b_r  <= a_r;
      eb_r <= ea_r;
    end else begin
      case (cmd.cap)
        tlca_pkg::CAP_A: begin
          a_r  <= raddr_r;
          ea_r <= rd_q_r;
        end
        tlca_pkg::CAP_B: begin
          b_r  <= raddr_r;
          eb_r <= rd_q_r;
        end
        tlca_pkg::CAP_T: begin
          dt_r <= rd_q_r.depth;
          jt_r <= rd_q_r.jump;
        end
        tlca_pkg::CAP_T2: begin
          dt2_r <= rd_q_r.depth;
        end
        default: begin
        end
      endcase
    end
    if (cmd.res_load) begin
      res_anc_r <= (cmd.res_ok && cmd.res_anc) ? a_r : '0;
      res_st_r  <= cmd.res_ok ? tlca_pkg::STATUS_OK : tlca_pkg::STATUS_REJECTED;
    end
    if (cmd.out_load) begin
      out_anc_r <= res_anc_r;
      out_st_r  <= res_st_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_comb begin
    stat.op       = in_op_r;
    stat.a_zero   = (a_r == '0);
    stat.da_zero  = (ea_r.depth == '0);
    stat.b_zero   = (b_r == '0);
    stat.db_zero  = (eb_r.depth == '0);
    stat.a_deeper = (ea_r.depth > eb_r.depth);
    stat.b_deeper = (eb_r.depth > ea_r.depth);
    stat.t_ok     = (rd_q_r.depth >= eb_r.depth);
    stat.a_eq_b   = (a_r == b_r);
    stat.ja_ne_jb = (ea_r.jump != eb_r.jump);
    stat.out_busy = out_valid_r & ~out_tready;
  end

  assign out_tvalid = out_valid_r;
  assign out_anc    = out_anc_r;
  assign out_st     = out_st_r;

endmodule

@@ sv/tlca_ctrl.sv @@
// Controller: clearing pass, insert sequence and the two-phase ancestor walk.
module tlca_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  tlca_pkg::stat_t  stat,
  output tlca_pkg::cmd_t   cmd
);

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RD_A,
    ST_RD_B,
    ST_CAP_B,
    ST_EVAL,
    ST_I_P1,
    ST_I_P2,
    ST_I_CP2,
    ST_I_WR,
    ST_L1_CHK,
    ST_L1_T,
    ST_L1_P,
    ST_L2_CHK,
    ST_L2_JB,
    ST_L2_PB,
    ST_L2_CB,
    ST_FIN
  } state_t;

  state_t        state_r;
  state_t        state_nxt;
  tlca_pkg::id_t clr_cnt_r;
  tlca_pkg::id_t clr_cnt_nxt;
  logic          ins_ok;
  logic          qry_ok;

  assign ins_ok = ~stat.a_zero & stat.da_zero & (stat.b_zero | ~stat.db_zero);
  assign qry_ok = ~stat.a_zero & ~stat.da_zero & ~stat.b_zero & ~stat.db_zero;

  assign in_tready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt   = state_r;
    clr_cnt_nxt = clr_cnt_r;
    cmd         = '0;
    cmd.rd_src  = tlca_pkg::SRC_IN_A;
    cmd.cap     = tlca_pkg::CAP_NONE;
    cmd.clr_addr = clr_cnt_r;
    case (state_r)
      ST_CLEAR: begin
        cmd.wr_clr  = 1'b1;
        clr_cnt_nxt = clr_cnt_r + tlca_pkg::ID_W'(1);
        if (clr_cnt_r == tlca_pkg::ID_W'(tlca_pkg::NODE_COUNT - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd.load_in = 1'b1;
          state_nxt   = ST_RD_A;
        end
      end
      ST_RD_A: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_src = tlca_pkg::SRC_IN_A;
        state_nxt  = ST_RD_B;
      end
      ST_RD_B: begin
        cmd.cap    = tlca_pkg::CAP_A;
        cmd.rd_en  = 1'b1;
        cmd.rd_src = tlca_pkg::SRC_IN_B;
        state_nxt  = ST_CAP_B;
      end
      ST_CAP_B: begin
        cmd.cap   = tlca_pkg::CAP_B;
        state_nxt = ST_EVAL;
      end
      ST_EVAL: begin
        if (stat.op == tlca_pkg::OP_INSERT) begin
          if (ins_ok) begin
            state_nxt = ST_I_P1;
          end else begin
            cmd.res_load = 1'b1;
            state_nxt    = ST_FIN;
          end
        end else if (qry_ok) begin
          cmd.swap  = stat.b_deeper;
          state_nxt = ST_L1_CHK;
        end else begin
          cmd.res_load = 1'b1;
          state_nxt    = ST_FIN;
        end
      end
      ST_I_P1: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_src = tlca_pkg::SRC_JB;
        state_nxt  = ST_I_P2;
      end
      ST_I_P2: begin
        cmd.cap    = tlca_pkg::CAP_T;
        cmd.rd_en  = 1'b1;
        cmd.rd_src = tlca_pkg::SRC_RD_JUMP;
        state_nxt  = ST_I_CP2;
      end
      ST_I_CP2: begin
        cmd.cap   = tlca_pkg::CAP_T2;
        state_nxt = ST_I_WR;
      end
      ST_I_WR: begin
        cmd.wr_node  = 1'b1;
        cmd.res_load = 1'b1;
        cmd.res_ok   = 1'b1;
        state_nxt    = ST_FIN;
      end
      ST_L1_CHK: begin
        if (stat.a_deeper) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_src = tlca_pkg::SRC_JA;
          state_nxt  = ST_L1_T;
        end else begin
          state_nxt = ST_L2_CHK;
        end
      end
      ST_L1_T: begin
        if (stat.t_ok) begin
          cmd.cap   = tlca_pkg::CAP_A;
          state_nxt = ST_L1_CHK;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_src = tlca_pkg::SRC_PA;
          state_nxt  = ST_L1_P;
        end
      end
      ST_L1_P: begin
        cmd.cap   = tlca_pkg::CAP_A;
        state_nxt = ST_L1_CHK;
      end
      ST_L2_CHK: begin
        if (stat.a_eq_b) begin
          cmd.res_load = 1'b1;
          cmd.res_ok   = 1'b1;
          cmd.res_anc  = 1'b1;
          state_nxt    = ST_FIN;
        end else if (stat.ja_ne_jb) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_src = tlca_pkg::SRC_JA;
          state_nxt  = ST_L2_JB;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_src = tlca_pkg::SRC_PA;
          state_nxt  = ST_L2_PB;
        end
      end
      ST_L2_JB: begin
        cmd.cap    = tlca_pkg::CAP_A;
        cmd.rd_en  = 1'b1;
        cmd.rd_src = tlca_pkg::SRC_JB;
        state_nxt  = ST_L2_CB;
      end
      ST_L2_PB: begin
        cmd.cap    = tlca_pkg::CAP_A;
        cmd.rd_en  = 1'b1;
        cmd.rd_src = tlca_pkg::SRC_PB;
        state_nxt  = ST_L2_CB;
      end
      ST_L2_CB: begin
        cmd.cap   = tlca_pkg::CAP_B;
        state_nxt = ST_L2_CHK;
      end
      ST_FIN: begin
        if (!stat.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLEAR;
      clr_cnt_r <= '0;
    end else begin
      state_r   <= state_nxt;
      clr_cnt_r <= clr_cnt_nxt;
    end
  end

endmodule

@@ sv/tree_lca_jump_pointer_engine_core.sv @@
// Top level of the lowest-common-ancestor engine over a jump-pointer node table.
//
// The engine keeps a forest of up to 1023 nodes (node 0 is a sentinel) in a
// single-port node table holding depth, parent and jump pointer per node.
// Input transfers on the in_ channel carry one command: in_tuser selects an
// insert (0) or a query (1); in_tdata holds the two node ids. Each input
// transfer produces exactly one output transfer on the out_ channel carrying
// the ancestor id (zero for inserts and rejections) and a rejected flag.
// Items are handled one at a time: every table access is one read with a
// registered result, which the controller captures in the state after the
// read. An insert reads the operands, the parent's jump and that node's jump,
// then writes the new entry; a query lifts the deeper node by jump or parent
// steps and then climbs both nodes together by jump or parent steps. The
// result moves to the output register once that register is free.
// After reset the controller sweeps the table to zero, one entry per cycle,
// over all 1024 entries; in_tready stays low until the sweep has finished.
// A finished result sits in the output register while the next input
// transfer is accepted and processed; if the receiver stalls, the engine
// holds its next result internally and takes no further input until the
// output register frees.
module tree_lca_jump_pointer_engine_core (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [tlca_pkg::IN_TDATA_W-1:0]      in_tdata,   // node_a, node_b, zero pad
  input  logic                                 in_tuser,   // operation
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [tlca_pkg::OUT_TDATA_W-1:0]     out_tdata,  // ancestor, zero pad
  output logic                                 out_tuser   // status
);

  tlca_pkg::cmd_t  cmd;
  tlca_pkg::stat_t stat;
  tlca_pkg::id_t   node_a;
  tlca_pkg::id_t   node_b;
  tlca_pkg::id_t   ancestor;

  assign node_a = in_tdata[tlca_pkg::ID_W-1:0];
  assign node_b = in_tdata[2*tlca_pkg::ID_W-1:tlca_pkg::ID_W];

  tlca_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  tlca_dpath u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_op      (in_tuser),
    .in_a       (node_a),
    .in_b       (node_b),
    .cmd        (cmd),
    .stat       (stat),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_anc    (ancestor),
    .out_st     (out_tuser)
  );

  // Ancestor in the low bits, the rest of the byte-aligned word zero.
  assign out_tdata = tlca_pkg::OUT_TDATA_W'(ancestor);

endmodule

@@ sv/tlca_checker.sv @@
// Port-level checker for the LCA engine, bound to the top level.
module tlca_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [tlca_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic                             out_tuser
);

  // Reset leaves the engine clearing its table with nothing to deliver.
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !in_tready && !out_tvalid)
    else $error("engine not quiet after reset");

  // One item at a time: an input transfer closes the input side.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted while an item is in progress");

  // A rejected result carries no ancestor.
  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata == '0)
    else $error("rejected result with nonzero ancestor");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

endmodule

bind tree_lca_jump_pointer_engine_core tlca_checker u_tlca_checker (.*);

@@ verif/tree_lca_jump_pointer_engine_core_test.sv @@
// Self-checking testbench for the LCA jump-pointer engine: forest inserts and ancestor queries.
`timescale 1ns / 100ps

// One expected transfer on the result channel.
typedef struct packed {
  tlca_pkg::id_t ancestor;
  logic          status;
} lca_result_t;

// Scoreboard: keeps its own copy of the node table, works out the answer to
// every accepted command and compares it with the result transfers in order.
class lca_scoreboard;
  int unsigned depth_of  [tlca_pkg::NODE_COUNT];
  int unsigned parent_of [tlca_pkg::NODE_COUNT];
  int unsigned jump_of   [tlca_pkg::NODE_COUNT];
  lca_result_t pending_results[$];
  int          errors;
  int          inserts_ok;
  int          queries_ok;
  int          rejected;
  int          disjoint_queries;
  int unsigned deepest;

  function new();
    foreach (depth_of[i]) begin
      depth_of[i]  = 0;
      parent_of[i] = 0;
      jump_of[i]   = 0;
    end
    errors           = 0;
    inserts_ok       = 0;
    queries_ok       = 0;
    rejected         = 0;
    disjoint_queries = 0;
    deepest          = 0;
  endfunction

  function bit is_present(int unsigned id);
    return id != 0 && id < tlca_pkg::NODE_COUNT && depth_of[id] != 0;
  endfunction

  // Lift the deeper node to the shallower one's depth, then climb both in step.
  function int unsigned common_ancestor(int unsigned x, int unsigned y);
    int unsigned t;
    if (depth_of[y] > depth_of[x]) begin
      t = x;
      x = y;
      y = t;
    end
    while (depth_of[x] > depth_of[y]) begin
      t = jump_of[x];
      x = (depth_of[t] >= depth_of[y]) ? t : parent_of[x];
    end
    while (x != y) begin
      if (jump_of[x] != jump_of[y]) begin
        x = jump_of[x];
        y = jump_of[y];
      end else begin
        x = parent_of[x];
        y = parent_of[y];
      end
    end
    return x;
  endfunction

  function void note_input(logic op, tlca_pkg::id_t a, tlca_pkg::id_t b);
    lca_result_t res;
    int unsigned p1;
    int unsigned p2;
    res.ancestor = '0;
    res.status   = tlca_pkg::STATUS_REJECTED;
    if (op == tlca_pkg::OP_INSERT) begin
      if (a != 0 && depth_of[a] == 0 && (b == 0 || is_present(b))) begin
        p1 = jump_of[b];
        p2 = jump_of[p1];
        depth_of[a]  = depth_of[b] + 1;
        parent_of[a] = b;
        // Skew-binary rule: point at the jump's jump when the two gaps match.
        jump_of[a]   = ((depth_of[p1] - depth_of[b]) == (depth_of[p2] - depth_of[p1])) ? p2 : b;
        res.status   = tlca_pkg::STATUS_OK;
        inserts_ok++;
        if (depth_of[a] > deepest) deepest = depth_of[a];
      end
    end else if (is_present(a) && is_present(b)) begin
      res.ancestor = tlca_pkg::id_t'(common_ancestor(a, b));
      res.status   = tlca_pkg::STATUS_OK;
      queries_ok++;
      if (res.ancestor == 0) disjoint_queries++;
    end
    if (res.status == tlca_pkg::STATUS_REJECTED) rejected++;
    pending_results.push_back(res);
  endfunction

  function void check_result(tlca_pkg::id_t ancestor, logic status);
    lca_result_t want;
    if (pending_results.size() == 0) begin
      errors++;
      if (errors <= 10)
        $display("ERROR: result with nothing outstanding: ancestor %0d status %0d",
                 ancestor, status);
      return;
    end
    want = pending_results.pop_front();
    if (want.ancestor !== ancestor || want.status !== status) begin
      errors++;
      if (errors <= 10)
        $display("ERROR: expected ancestor %0d status %0d, got ancestor %0d status %0d",
                 want.ancestor, want.status, ancestor, status);
    end
  endfunction
endclass

module tree_lca_jump_pointer_engine_core_test;

  // Longest stretch without any transfer before the run is declared hung. The
  // table sweep after reset alone runs with no transfer.
  localparam int STALL_LIMIT  = 4000;
  localparam int RANDOM_ITEMS = 1030;
  // The final stretch of random items runs with neither side idling.
  localparam int CALM_TAIL    = 150;

  logic                                 clk;
  logic                                 rst_n      = 1'b0;
  logic                                 in_tvalid  = 1'b0;
  logic                                 in_tready;
  logic [tlca_pkg::IN_TDATA_W-1:0]      in_tdata   = '0;
  logic                                 in_tuser   = tlca_pkg::OP_INSERT;
  logic                                 out_tvalid;
  logic                                 out_tready = 1'b0;
  logic [tlca_pkg::OUT_TDATA_W-1:0]     out_tdata;
  logic                                 out_tuser;

  lca_scoreboard sb = new();

  // The stimulus generator keeps its own view of which ids are present, so
  // that it never has to read the scoreboard in the same time step as the
  // monitor updates it.
  bit            gen_present [tlca_pkg::NODE_COUNT];
  tlca_pkg::id_t gen_live[$];
  tlca_pkg::id_t gen_last;
  bit            idling_on = 1'b1;
  int            idle_cycles = 0;

  tree_lca_jump_pointer_engine_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Monitor and watchdog. Both channels are sampled at the rising edge, where
  // the values seen are those from before the edge, so a transfer is counted
  // exactly when the block itself sees valid and ready high together.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready)
        sb.note_input(in_tuser, in_tdata[tlca_pkg::ID_W-1:0],
                      in_tdata[2*tlca_pkg::ID_W-1:tlca_pkg::ID_W]);
      if (out_tvalid && out_tready)
        sb.check_result(out_tdata[tlca_pkg::ID_W-1:0], out_tuser);
    end
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= STALL_LIMIT) begin
      $display("Timeout: no transfer for %0d cycles", STALL_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Result receiver: ready most of the time, with short random stalls while
  // idling is allowed.
  initial begin
    @(posedge clk);
    forever begin
      if (idling_on && $urandom_range(0, 2) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk);
      end
      out_tready <= 1'b1;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  end

  // Offers one command and returns at the edge where it is accepted. Valid is
  // left high, so back-to-back commands need no second assignment in one step.
  task automatic send_item(input logic op, input tlca_pkg::id_t a, input tlca_pkg::id_t b);
    if (idling_on && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {{(tlca_pkg::IN_TDATA_W - 2 * tlca_pkg::ID_W){1'b0}}, b, a};
    // Mirror the insert in the generator's view of the forest.
    if (op == tlca_pkg::OP_INSERT && a != 0 && !gen_present[a] &&
        (b == 0 || gen_present[b])) begin
      gen_present[a] = 1'b1;
      gen_live.push_back(a);
      gen_last = a;
    end
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // Holds the sender off until every outstanding result has come back.
  task automatic drain_results();
    in_tvalid <= 1'b0;
    do @(negedge clk); while (sb.pending_results.size() != 0);
    @(posedge clk);
  endtask

  function automatic tlca_pkg::id_t pick_free_id();
    tlca_pkg::id_t cand;
    for (int k = 0; k < 64; k++) begin
      cand = tlca_pkg::id_t'($urandom_range(1, tlca_pkg::NODE_COUNT - 1));
      if (!gen_present[cand]) return cand;
    end
    for (int k = 1; k < tlca_pkg::NODE_COUNT; k++)
      if (!gen_present[k]) return tlca_pkg::id_t'(k);
    return '0;
  endfunction

  function automatic tlca_pkg::id_t pick_live_id();
    return gen_live[$urandom_range(0, gen_live.size() - 1)];
  endfunction

  initial begin
    int            roll;
    logic          op;
    tlca_pkg::id_t a;
    tlca_pkg::id_t b;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: rejections of every kind, ids at both ends of the range,
    // two separate trees, and queries in both argument orders.
    send_item(tlca_pkg::OP_INSERT, 10'd0,    10'd0);     // node 0 cannot be inserted
    send_item(tlca_pkg::OP_INSERT, 10'd1,    10'd0);     // first root
    send_item(tlca_pkg::OP_INSERT, 10'd1,    10'd0);     // duplicate
    send_item(tlca_pkg::OP_INSERT, 10'd5,    10'd7);     // parent not present
    send_item(tlca_pkg::OP_INSERT, 10'd9,    10'd9);     // child equals an absent parent
    send_item(tlca_pkg::OP_INSERT, 10'd1,    10'd1);     // child equals a present parent
    send_item(tlca_pkg::OP_INSERT, 10'd1023, 10'd1);
    send_item(tlca_pkg::OP_INSERT, 10'd512,  10'd1023);
    send_item(tlca_pkg::OP_INSERT, 10'd4,    10'd1023);
    send_item(tlca_pkg::OP_INSERT, 10'd2,    10'd0);     // second, separate tree
    send_item(tlca_pkg::OP_INSERT, 10'd3,    10'd2);
    send_item(tlca_pkg::OP_INSERT, 10'd1022, 10'd3);
    send_item(tlca_pkg::OP_QUERY,  10'd0,    10'd1);     // node 0 in a query
    send_item(tlca_pkg::OP_QUERY,  10'd0,    10'd0);
    send_item(tlca_pkg::OP_QUERY,  10'd1,    10'd600);   // absent node
    send_item(tlca_pkg::OP_QUERY,  10'd512,  10'd1022);  // different trees
    send_item(tlca_pkg::OP_QUERY,  10'd512,  10'd4);     // siblings
    send_item(tlca_pkg::OP_QUERY,  10'd512,  10'd1023);  // node and its parent
    send_item(tlca_pkg::OP_QUERY,  10'd1,    10'd512);   // deeper node second
    send_item(tlca_pkg::OP_QUERY,  10'd512,  10'd512);   // node with itself
    send_item(tlca_pkg::OP_QUERY,  10'd1022, 10'd2);
    send_item(tlca_pkg::OP_QUERY,  10'd1023, 10'd1);

    drain_results();

    // Random part: mostly well-formed inserts and queries on the growing
    // forest, with some raw items over the whole id range as noise. Inserts
    // often hang off the most recent node so that deep chains build up.
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == RANDOM_ITEMS / 2) drain_results();
      if (i == RANDOM_ITEMS - CALM_TAIL) idling_on = 1'b0;
      roll = $urandom_range(0, 99);
      if (roll < 40 || gen_live.size() == 0) begin
        op   = tlca_pkg::OP_INSERT;
        a    = pick_free_id();
        roll = $urandom_range(0, 99);
        if (roll < 10 || gen_live.size() == 0) b = '0;
        else if (roll < 55) b = gen_last;
        else b = pick_live_id();
      end else if (roll < 85) begin
        op = tlca_pkg::OP_QUERY;
        a  = pick_live_id();
        b  = pick_live_id();
      end else begin
        op = logic'($urandom_range(0, 1));
        a  = tlca_pkg::id_t'($urandom_range(0, tlca_pkg::NODE_COUNT - 1));
        if ($urandom_range(0, 7) == 0) a = '0;
        b  = tlca_pkg::id_t'($urandom_range(0, tlca_pkg::NODE_COUNT - 1));
        if ($urandom_range(0, 7) == 0) b = '0;
      end
      send_item(op, a, b);
    end

    in_tvalid <= 1'b0;
    do @(negedge clk); while (sb.pending_results.size() != 0);
    repeat (40) @(posedge clk);

    if (sb.pending_results.size() != 0) begin
      sb.errors++;
      $display("ERROR: %0d results never arrived", sb.pending_results.size());
    end

    $display("Covered %0d good inserts and %0d good queries (%0d across separate trees),",
             sb.inserts_ok, sb.queries_ok, sb.disjoint_queries);
    $display("%0d rejected commands, forest depth up to %0d; %0d errors.",
             sb.rejected, sb.deepest, sb.errors);
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

@@ sim.f @@
sv/tlca_pkg.sv
sv/tlca_dpath.sv
sv/tlca_ctrl.sv
sv/tree_lca_jump_pointer_engine_core.sv
sv/tlca_checker.sv
verif/tree_lca_jump_pointer_engine_core_test.sv
